[design/pid_pkg.sv]
// Shared types, register indexes and the clamp function of the PID step block.
package pid_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int LIMIT_W  = 32;
    localparam int ACC_W    = 44;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIM_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO    = 3'd6;

    localparam logic signed [LIMIT_W-1:0] LIM_LO_RESET = 32'shFFFF_0000;
    localparam logic signed [LIMIT_W-1:0] LIM_HI_RESET = 32'sh0001_0000;

    typedef struct packed {
        logic [GAIN_W-1:0]         gain_p;
        logic [GAIN_W-1:0]         gain_i;
        logic [GAIN_W-1:0]         gain_d;
        logic                      reverse;
        logic signed [LIMIT_W-1:0] lim_lo;
        logic signed [LIMIT_W-1:0] lim_hi;
        logic                      auto_mode;
    } t_cfg;

    // Upper limit is tested first, so with crossed limits a value above the upper limit resolves to the upper one.
    function automatic logic signed [LIMIT_W-1:0] clamp_acc(
        input logic signed [ACC_W-1:0]   x,
        input logic signed [LIMIT_W-1:0] lo,
        input logic signed [LIMIT_W-1:0] hi
    );
        logic signed [ACC_W-1:0] hi_w;
        logic signed [ACC_W-1:0] lo_w;
        hi_w = ACC_W'(hi);
        lo_w = ACC_W'(lo);
        if (x > hi_w) begin
            return hi;
        end else if (x < lo_w) begin
            return lo;
        end else begin
            return $signed(x[LIMIT_W-1:0]);
        end
    endfunction

endpackage

[design/pid_cfg.sv]
// Configuration register file of the PID step block.
module pid_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_wr_en,
    input  logic [pid_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [pid_pkg::LIMIT_W-1:0]    i_wr_data,
    output pid_pkg::t_cfg                  o_cfg,
    output logic                           o_auto_enter
);

    pid_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p    <= '0;
            r_cfg.gain_i    <= '0;
            r_cfg.gain_d    <= '0;
            r_cfg.reverse   <= 1'b0;
            r_cfg.lim_lo    <= pid_pkg::LIM_LO_RESET;
            r_cfg.lim_hi    <= pid_pkg::LIM_HI_RESET;
            r_cfg.auto_mode <= 1'b1;
        end else if (i_wr_en) begin
            case (i_wr_index)
                pid_pkg::REG_GAIN_P:  r_cfg.gain_p    <= i_wr_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_I:  r_cfg.gain_i    <= i_wr_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_GAIN_D:  r_cfg.gain_d    <= i_wr_data[pid_pkg::GAIN_W-1:0];
                pid_pkg::REG_REVERSE: r_cfg.reverse   <= i_wr_data[0];
                pid_pkg::REG_LIM_LO:  r_cfg.lim_lo    <= $signed(i_wr_data);
                pid_pkg::REG_LIM_HI:  r_cfg.lim_hi    <= $signed(i_wr_data);
                pid_pkg::REG_AUTO:    r_cfg.auto_mode <= i_wr_data[0];
                default: ;
            endcase
        end
    end

    // Manual to automatic switch: core clamps the integral once.
    assign o_auto_enter = i_wr_en && (i_wr_index == pid_pkg::REG_AUTO) &&
                          i_wr_data[0] && !r_cfg.auto_mode;
    assign o_cfg = r_cfg;

endmodule

[design/pid_core.sv]
// PID arithmetic and controller state: integral, last measurement, held drive.
module pid_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  logic signed [pid_pkg::SAMPLE_W-1:0]   i_target,
    input  logic signed [pid_pkg::SAMPLE_W-1:0]   i_measured,
    input  pid_pkg::t_cfg                         i_cfg,
    input  logic                                  i_auto_enter,
    output logic signed [pid_pkg::LIMIT_W-1:0]    o_drive
);

    logic signed [pid_pkg::SAMPLE_W-1:0] r_prev_meas;
    logic signed [pid_pkg::LIMIT_W-1:0]  r_integral;
    logic signed [pid_pkg::LIMIT_W-1:0]  r_held;

    logic signed [pid_pkg::SAMPLE_W:0]   err;
    logic signed [pid_pkg::SAMPLE_W:0]   delta;
    logic signed [pid_pkg::GAIN_W:0]     gain_p_s;
    logic signed [pid_pkg::GAIN_W:0]     gain_i_s;
    logic signed [pid_pkg::GAIN_W:0]     gain_d_s;
    logic signed [pid_pkg::GAIN_W+pid_pkg::SAMPLE_W+1:0] prod_p;
    logic signed [pid_pkg::GAIN_W+pid_pkg::SAMPLE_W+1:0] prod_i;
    logic signed [pid_pkg::GAIN_W+pid_pkg::SAMPLE_W+1:0] prod_d;
    logic signed [pid_pkg::ACC_W-1:0]    int_acc;
    logic signed [pid_pkg::LIMIT_W-1:0]  int_new;
    logic signed [pid_pkg::ACC_W-1:0]    drv_acc;
    logic signed [pid_pkg::LIMIT_W-1:0]  drv_new;

    always_comb begin
        err   = (pid_pkg::SAMPLE_W+1)'(i_target) - (pid_pkg::SAMPLE_W+1)'(i_measured);
        delta = (pid_pkg::SAMPLE_W+1)'(i_measured) - (pid_pkg::SAMPLE_W+1)'(r_prev_meas);

        // Reverse acting: negate all three gains.
        gain_p_s = i_cfg.reverse ? -$signed({1'b0, i_cfg.gain_p}) : $signed({1'b0, i_cfg.gain_p});
        gain_i_s = i_cfg.reverse ? -$signed({1'b0, i_cfg.gain_i}) : $signed({1'b0, i_cfg.gain_i});
        gain_d_s = i_cfg.reverse ? -$signed({1'b0, i_cfg.gain_d}) : $signed({1'b0, i_cfg.gain_d});

        prod_p = gain_p_s * err;
        prod_i = gain_i_s * err;
        prod_d = gain_d_s * delta;

        int_acc = pid_pkg::ACC_W'(r_integral) + pid_pkg::ACC_W'(prod_i);
        int_new = pid_pkg::clamp_acc(int_acc, i_cfg.lim_lo, i_cfg.lim_hi);

        drv_acc = pid_pkg::ACC_W'(prod_p) + pid_pkg::ACC_W'(int_new)
                - pid_pkg::ACC_W'(prod_d);
        drv_new = pid_pkg::clamp_acc(drv_acc, i_cfg.lim_lo, i_cfg.lim_hi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_meas <= '0;
            r_integral  <= '0;
            r_held      <= '0;
        end else if (i_advance) begin
            r_prev_meas <= i_measured;
            if (i_cfg.auto_mode) begin
                r_integral <= int_new;
                r_held     <= drv_new;
            end else begin
                // Manual tracking: preload the integral for a bumpless return.
                r_integral <= r_held;
            end
        end else if (i_auto_enter) begin
            r_integral <= pid_pkg::clamp_acc(pid_pkg::ACC_W'(r_integral),
                                             i_cfg.lim_lo, i_cfg.lim_hi);
        end
    end

    assign o_drive = i_cfg.auto_mode ? drv_new : '0;

endmodule

[design/pid_controller_step.sv]
// Top level of the PID step block: handshake, sample and result registers.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+-------------------------------
//  sample   | in        | i_valid / o_ready            | i_target, i_measured (s16)
//  drive    | out       | o_valid / i_ready            | o_drive (s32, Q16.16)
//  config   | in        | i_cfg_valid / o_cfg_ready    | i_cfg_index (3b), i_cfg_data (32b)
//
// One sample per clock sustained while i_ready is high. The sample register
// feeds one pass of multiply, add and clamp into the result register.
// Synchronous active-low reset clears the valid flags, the controller state
// and the config registers to their defaults, but not the payload registers.
// A stall on the drive side holds the sample register and propagates to
// o_ready; the sample register still refills while a finished drive waits.
// Config transfers are held off while a sample sits in the sample register.
module pid_controller_step (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [pid_pkg::SAMPLE_W-1:0]  i_target,
    input  logic signed [pid_pkg::SAMPLE_W-1:0]  i_measured,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [pid_pkg::LIMIT_W-1:0]   o_drive,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [pid_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [pid_pkg::LIMIT_W-1:0]          i_cfg_data
);

    logic                                 r_s1_valid;
    logic signed [pid_pkg::SAMPLE_W-1:0]  r_target;
    logic signed [pid_pkg::SAMPLE_W-1:0]  r_measured;
    logic                                 r_out_valid;
    logic signed [pid_pkg::LIMIT_W-1:0]   r_drive;

    logic                                 advance;
    logic                                 in_xfer;
    logic                                 cfg_xfer;
    pid_pkg::t_cfg                        cfg;
    logic                                 auto_enter;
    logic signed [pid_pkg::LIMIT_W-1:0]   n_drive;

    // Advance the sample into the result register when that slot is free
    // or is being drained this cycle.
    assign advance     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || advance;
    assign in_xfer     = i_valid && o_ready;
    assign o_cfg_ready = !r_s1_valid;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;

    pid_cfg u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (cfg_xfer),
        .i_wr_index   (i_cfg_index),
        .i_wr_data    (i_cfg_data),
        .o_cfg        (cfg),
        .o_auto_enter (auto_enter)
    );

    pid_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (advance),
        .i_target     (r_target),
        .i_measured   (r_measured),
        .i_cfg        (cfg),
        .i_auto_enter (auto_enter),
        .o_drive      (n_drive)
    );

    // Sample register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Sample payload: load on transfer, otherwise hold.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_target   <= i_target;
            r_measured <= i_measured;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_out_valid;
    assign o_drive = r_drive;

endmodule
